// File: rtl/bzr_pkg.sv
package bzr_pkg;

	localparam int MAX_CHECK  = 32;
	localparam int MAX_POINTS = 64;
	localparam int CHK_AW     = $clog2(MAX_CHECK);
	localparam int LEN_W      = 32;
	localparam int DIV_W      = 50;
	localparam logic [5:0] CHECK_POINTS_RST = 6'd25;

	typedef struct packed {
		logic signed [23:0] p0_x;
		logic signed [23:0] p0_y;
		logic signed [23:0] p1_x;
		logic signed [23:0] p1_y;
		logic signed [23:0] p2_x;
		logic signed [23:0] p2_y;
		logic signed [23:0] p3_x;
		logic signed [23:0] p3_y;
		logic        [23:0] density;
	} bzr_in_t;

	typedef struct packed {
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic               last;
		logic               clipped;
	} bzr_out_t;

endpackage

// File: rtl/bzr_ram.sv
module bzr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, and read through a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/bezier_arc_length_resampler_top.sv
// Cubic Bezier arc-length resampler: one curve in, 1 to 64 equally spaced points out.
// Each length sample after the first takes a serial divide, Horner evaluation and a bit-serial
// square root; each emitted point takes up to three serial divides, a binary search in the
// length RAM and an evaluation.
// One curve at a time; the next curve is taken once the last point sits in the output register.
// Reset (arst_n low) idles the sequencer, empties the output and sets check_points to 25.
module bezier_arc_length_resampler_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [5:0]       cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  bzr_pkg::bzr_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bzr_pkg::bzr_out_t out_data
);
	import bzr_pkg::*;

	typedef enum logic [21:0] {
		ST_IDLE  = 22'd1 << 0,
		ST_TDIV  = 22'd1 << 1,
		ST_TWAIT = 22'd1 << 2,
		ST_EVAL  = 22'd1 << 3,
		ST_SQX   = 22'd1 << 4,
		ST_SQY   = 22'd1 << 5,
		ST_SQRT  = 22'd1 << 6,
		ST_ACC   = 22'd1 << 7,
		ST_CNT0  = 22'd1 << 8,
		ST_CNT1  = 22'd1 << 9,
		ST_CNT2  = 22'd1 << 10,
		ST_TGT0  = 22'd1 << 11,
		ST_TGT1  = 22'd1 << 12,
		ST_TGTW  = 22'd1 << 13,
		ST_BS    = 22'd1 << 14,
		ST_BSR   = 22'd1 << 15,
		ST_LB    = 22'd1 << 16,
		ST_SPAN  = 22'd1 << 17,
		ST_FRACW = 22'd1 << 18,
		ST_TN    = 22'd1 << 19,
		ST_TNW   = 22'd1 << 20,
		ST_OUT   = 22'd1 << 21
	} state_t;

	state_t state_q;

	logic [5:0]  check_points_q;
	logic [5:0]  n_q;
	logic [CHK_AW-1:0] nm1;
	logic [CHK_AW-1:0] i_q;
	logic [CHK_AW-1:0] lo_q, hi_q;
	logic [5:0]  lohi;
	logic        resample_q;

	logic signed [29:0] ax_q, bx_q, cx_q, ay_q, by_q, cy_q;
	logic signed [23:0] p0x_q, p0y_q;
	logic        [23:0] den_q;
	logic signed [29:0] ax_c, bx_c, cx_c, ay_c, by_c, cy_c;

	// Horner evaluation unit
	logic signed [29:0] v_q;
	logic signed [47:0] prod_q;
	logic        [16:0] t_q;
	logic        [2:0]  ev_cnt_q;
	logic               ev_ph_q;
	logic signed [47:0] rnd_v;
	logic signed [31:0] hsum;
	logic signed [29:0] hcoef;
	logic signed [23:0] hsat;

	logic signed [23:0] px_q, py_q, pxp_q, pyp_q;
	logic signed [24:0] dx, dy;
	logic signed [49:0] dx_sq, dy_sq;
	logic        [49:0] sq_acc_q;

	// square root unit
	logic [49:0] sq_s_q;
	logic [26:0] sq_rem_q;
	logic [24:0] sq_root_q;
	logic [4:0]  sq_cnt_q;
	logic [26:0] sq_rem2, sq_trial;
	logic [24:0] sq_round;

	// divider unit
	logic [DIV_W-1:0] div_num_q, div_quot_q;
	logic [32:0]      div_rem_q, div_den_q;
	logic [5:0]       div_cnt_q;
	logic [33:0]      div_sh;
	logic             div_busy;

	logic [LEN_W-1:0] total_q, total_n, target_q, lb_q, span;
	logic [39:0] mp_q, mp_hi;
	logic [55:0] cprod_q;
	logic [32:0] cnt_sh;
	logic [38:0] tj_q;
	logic [6:0]  cnt_q, j_q;
	logic        clip_q;
	logic        out_load;

	logic                ram_we;
	logic [CHK_AW-1:0]   ram_waddr, ram_raddr;
	logic [LEN_W-1:0]    ram_wdata, ram_rdata;

	bzr_ram #(.WIDTH(LEN_W), .DEPTH(MAX_CHECK)) u_len_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign nm1       = CHK_AW'(n_q - 6'd1);
	assign lohi      = {1'b0, lo_q} + {1'b0, hi_q};
	assign out_load  = (state_q == ST_OUT) && (!out_valid || out_ready);

	// form Horner coefficients of the incoming curve
	always_comb begin
		ax_c = -30'(in_data.p0_x) + 30'sd3 * 30'(in_data.p1_x)
			- 30'sd3 * 30'(in_data.p2_x) + 30'(in_data.p3_x);
		bx_c = 30'sd3 * 30'(in_data.p0_x) - 30'sd6 * 30'(in_data.p1_x)
			+ 30'sd3 * 30'(in_data.p2_x);
		cx_c = -30'sd3 * 30'(in_data.p0_x) + 30'sd3 * 30'(in_data.p1_x);
		ay_c = -30'(in_data.p0_y) + 30'sd3 * 30'(in_data.p1_y)
			- 30'sd3 * 30'(in_data.p2_y) + 30'(in_data.p3_y);
		by_c = 30'sd3 * 30'(in_data.p0_y) - 30'sd6 * 30'(in_data.p1_y)
			+ 30'sd3 * 30'(in_data.p2_y);
		cy_c = -30'sd3 * 30'(in_data.p0_y) + 30'sd3 * 30'(in_data.p1_y);
	end

	// Horner add phase: round the product, add the next coefficient, saturate
	always_comb begin
		case (ev_cnt_q)
			3'd0:    hcoef = bx_q;
			3'd1:    hcoef = cx_q;
			3'd2:    hcoef = 30'(p0x_q);
			3'd3:    hcoef = by_q;
			3'd4:    hcoef = cy_q;
			default: hcoef = 30'(p0y_q);
		endcase
		rnd_v = (prod_q + 48'sd32768) >>> 16;
		hsum  = 32'(rnd_v) + 32'(hcoef);
		if (hsum > 32'sd8388607) begin
			hsat = 24'sd8388607;
		end else if (hsum < -32'sd8388608) begin
			hsat = -24'sd8388608;
		end else begin
			hsat = 24'(hsum);
		end
	end

	// chord deltas, root step, divider step
	assign dx       = 25'(px_q) - 25'(pxp_q);
	assign dy       = 25'(py_q) - 25'(pyp_q);
	assign dx_sq    = dx * dx;
	assign dy_sq    = dy * dy;
	assign sq_rem2  = {sq_rem_q[24:0], sq_s_q[49:48]};
	assign sq_trial = {sq_root_q, 2'b01};
	assign sq_round = sq_root_q + 25'(sq_rem_q > {2'b00, sq_root_q});
	assign div_sh   = {div_rem_q, div_num_q[DIV_W-1]};
	assign div_busy = (div_cnt_q != 6'd0);
	assign total_n  = total_q + LEN_W'(sq_round);
	assign span     = ram_rdata - lb_q;
	assign mp_hi    = den_q * total_q[31:16];
	assign cnt_sh   = 33'((cprod_q + 56'd8388608) >> 24);

	// length RAM ports
	always_comb begin
		ram_we    = (state_q == ST_ACC);
		ram_waddr = i_q;
		ram_wdata = (i_q == '0) ? '0 : total_n;
		case (state_q)
			ST_BS:   ram_raddr = (lo_q + 1'b1 < hi_q) ? lohi[CHK_AW:1] : lo_q;
			ST_LB:   ram_raddr = lo_q + 1'b1;
			default: ram_raddr = lo_q;
		endcase
	end

	// hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_points_q <= CHECK_POINTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			check_points_q <= cfg_data;
		end
	end

	// sequencer and shared arithmetic units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_valid  <= 1'b0;
			div_cnt_q  <= '0;
			sq_cnt_q   <= '0;
			ev_cnt_q   <= '0;
			ev_ph_q    <= 1'b0;
			resample_q <= 1'b0;
		end else begin
			// drop the output once taken, unless a new point replaces it
			if (out_valid && out_ready && !out_load) begin
				out_valid <= 1'b0;
			end

			// advance the restoring divider one quotient bit
			if (div_busy) begin
				div_num_q <= div_num_q << 1;
				if (div_sh >= {1'b0, div_den_q}) begin
					div_rem_q  <= 33'(div_sh - {1'b0, div_den_q});
					div_quot_q <= {div_quot_q[DIV_W-2:0], 1'b1};
				end else begin
					div_rem_q  <= div_sh[32:0];
					div_quot_q <= {div_quot_q[DIV_W-2:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q - 6'd1;
			end

			// advance the square root two radicand bits
			if (sq_cnt_q != 5'd0) begin
				sq_s_q <= sq_s_q << 2;
				if (sq_rem2 >= sq_trial) begin
					sq_rem_q  <= sq_rem2 - sq_trial;
					sq_root_q <= {sq_root_q[23:0], 1'b1};
				end else begin
					sq_rem_q  <= sq_rem2;
					sq_root_q <= {sq_root_q[23:0], 1'b0};
				end
				sq_cnt_q <= sq_cnt_q - 5'd1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ax_q  <= ax_c;
						bx_q  <= bx_c;
						cx_q  <= cx_c;
						ay_q  <= ay_c;
						by_q  <= by_c;
						cy_q  <= cy_c;
						p0x_q <= in_data.p0_x;
						p0y_q <= in_data.p0_y;
						den_q <= in_data.density;
						if (check_points_q < 6'd2) begin
							n_q <= 6'd2;
						end else if (check_points_q > 6'(MAX_CHECK)) begin
							n_q <= 6'(MAX_CHECK);
						end else begin
							n_q <= check_points_q;
						end
						i_q        <= '0;
						total_q    <= '0;
						resample_q <= 1'b0;
						state_q    <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					div_num_q  <= DIV_W'({i_q, 17'd0} + 23'(nm1)) << (DIV_W - 23);
					div_den_q  <= 33'({nm1, 1'b0});
					div_rem_q  <= '0;
					div_quot_q <= '0;
					div_cnt_q  <= 6'd23;
					state_q    <= ST_TWAIT;
				end
				ST_TWAIT: begin
					if (!div_busy) begin
						t_q      <= div_quot_q[16:0];
						v_q      <= ax_q;
						ev_cnt_q <= '0;
						ev_ph_q  <= 1'b0;
						state_q  <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!ev_ph_q) begin
						prod_q  <= v_q * $signed({1'b0, t_q});
						ev_ph_q <= 1'b1;
					end else begin
						ev_ph_q  <= 1'b0;
						ev_cnt_q <= ev_cnt_q + 3'd1;
						if (ev_cnt_q == 3'd2) begin
							px_q <= hsat;
							v_q  <= ay_q;
						end else if (ev_cnt_q == 3'd5) begin
							py_q <= hsat;
							if (resample_q) begin
								state_q <= ST_OUT;
							end else if (i_q == '0) begin
								state_q <= ST_ACC;
							end else begin
								state_q <= ST_SQX;
							end
						end else begin
							v_q <= 30'(hsum);
						end
					end
				end
				ST_SQX: begin
					sq_acc_q <= $unsigned(dx_sq);
					state_q  <= ST_SQY;
				end
				ST_SQY: begin
					sq_s_q    <= sq_acc_q + $unsigned(dy_sq);
					sq_rem_q  <= '0;
					sq_root_q <= '0;
					sq_cnt_q  <= 5'd25;
					state_q   <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_cnt_q == 5'd0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (i_q != '0) begin
						total_q <= total_n;
					end
					pxp_q <= px_q;
					pyp_q <= py_q;
					if (i_q == nm1) begin
						state_q <= ST_CNT0;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_TDIV;
					end
				end
				ST_CNT0: begin
					mp_q    <= den_q * total_q[15:0];
					state_q <= ST_CNT1;
				end
				ST_CNT1: begin
					cprod_q <= 56'(mp_q) + (56'(mp_hi) << 16);
					state_q <= ST_CNT2;
				end
				ST_CNT2: begin
					j_q        <= '0;
					resample_q <= 1'b1;
					if (cnt_sh >= 33'(MAX_POINTS)) begin
						cnt_q   <= 7'(MAX_POINTS);
						clip_q  <= 1'b1;
						state_q <= ST_TGT0;
					end else begin
						cnt_q  <= 7'(cnt_sh) + 7'd1;
						clip_q <= 1'b0;
						if (cnt_sh == 33'd0) begin
							px_q    <= p0x_q;
							py_q    <= p0y_q;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_TGT0;
						end
					end
				end
				ST_TGT0: begin
					tj_q    <= total_q * j_q;
					state_q <= ST_TGT1;
				end
				ST_TGT1: begin
					div_num_q  <= DIV_W'({tj_q, 1'b0} + 40'(cnt_q - 7'd1)) << (DIV_W - 40);
					div_den_q  <= 33'({cnt_q - 7'd1, 1'b0});
					div_rem_q  <= '0;
					div_quot_q <= '0;
					div_cnt_q  <= 6'd40;
					state_q    <= ST_TGTW;
				end
				ST_TGTW: begin
					if (!div_busy) begin
						target_q <= div_quot_q[LEN_W-1:0];
						lo_q     <= '0;
						hi_q     <= nm1;
						state_q  <= ST_BS;
					end
				end
				ST_BS: begin
					if (lo_q + 1'b1 < hi_q) begin
						state_q <= ST_BSR;
					end else begin
						state_q <= ST_LB;
					end
				end
				ST_BSR: begin
					if (ram_rdata <= target_q) begin
						lo_q <= lohi[CHK_AW:1];
					end else begin
						hi_q <= lohi[CHK_AW:1];
					end
					state_q <= ST_BS;
				end
				ST_LB: begin
					lb_q    <= ram_rdata;
					state_q <= ST_SPAN;
				end
				ST_SPAN: begin
					if (span != '0 && target_q > lb_q) begin
						div_num_q  <= DIV_W'({target_q - lb_q, 17'd0}) + DIV_W'(span);
						div_den_q  <= {span, 1'b0};
						div_rem_q  <= '0;
						div_quot_q <= '0;
						div_cnt_q  <= 6'd50;
						state_q    <= ST_FRACW;
					end else begin
						div_quot_q <= '0;
						state_q    <= ST_FRACW;
					end
				end
				ST_FRACW: begin
					if (!div_busy) begin
						state_q <= ST_TN;
					end
				end
				ST_TN: begin
					div_num_q <= DIV_W'({({lo_q, 16'd0} + 22'(
						(div_quot_q > DIV_W'(65536)) ? 17'd65536 : div_quot_q[16:0])), 1'b0}
						+ 24'(nm1)) << (DIV_W - 24);
					div_den_q  <= 33'({nm1, 1'b0});
					div_rem_q  <= '0;
					div_quot_q <= '0;
					div_cnt_q  <= 6'd24;
					state_q    <= ST_TNW;
				end
				ST_TNW: begin
					if (!div_busy) begin
						t_q      <= (div_quot_q > DIV_W'(65536)) ? 17'd65536 : div_quot_q[16:0];
						v_q      <= ax_q;
						ev_cnt_q <= '0;
						ev_ph_q  <= 1'b0;
						state_q  <= ST_EVAL;
					end
				end
				ST_OUT: begin
					// load the output register once it is free
					if (out_load) begin
						out_valid        <= 1'b1;
						out_data.out_x   <= px_q;
						out_data.out_y   <= py_q;
						out_data.last    <= (j_q + 7'd1 == cnt_q);
						out_data.clipped <= clip_q;
						if (j_q + 7'd1 == cnt_q) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + 7'd1;
							state_q <= ST_TGT0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sim/bzr_checker.sv
`timescale 1ns / 1ps

module bzr_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [5:0]        cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  bzr_pkg::bzr_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  bzr_pkg::bzr_out_t out_data,
	output int                fail_count,
	output int                points_pending
);
	import bzr_pkg::*;

	bzr_out_t   expected_points[$];
	logic [5:0] sample_setting;

	// Append one predicted point to the queue
	function automatic void enqueue_point(input bzr_out_t r);
		expected_points = {expected_points, r};
	endfunction

	// Saturate to the 24-bit signed output range
	function automatic longint clamp24(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	// Horner evaluation with round-to-nearest after each Q16 multiply
	function automatic longint curve_at(longint a, longint b, longint c, longint d, longint t);
		longint v;
		v = a;
		v = ((v * t + 32768) >>> 16) + b;
		v = ((v * t + 32768) >>> 16) + c;
		v = ((v * t + 32768) >>> 16) + d;
		return clamp24(v);
	endfunction

	// Integer square root, rounded to nearest
	function automatic longint unsigned root_round(longint unsigned s);
		longint unsigned r, probe, x;
		r = 0;
		x = s;
		probe = 64'd1 << 62;
		while (probe > s) probe >>= 2;
		while (probe != 0) begin
			if (x >= r + probe) begin
				x -= r + probe;
				r = (r >> 1) + probe;
			end else begin
				r >>= 1;
			end
			probe >>= 2;
		end
		if (s - r * r > r) r++;
		return r;
	endfunction

	// Build the chord table for one curve and queue every resampled point
	task automatic predict_curve(input bzr_in_t c);
		longint p[8];
		longint kx[4], ky[4];
		longint sx[MAX_CHECK], sy[MAX_CHECK];
		longint unsigned lens[MAX_CHECK];
		longint unsigned n, den, total, cnt, tgt, lb, span, frac, tn, ti;
		longint dx, dy, vx, vy;
		int lo, hi, mid;
		logic clip;
		bzr_out_t r;
		n = sample_setting;
		if (n < 2) n = 2;
		if (n > MAX_CHECK) n = MAX_CHECK;
		p[0] = $signed(c.p0_x); p[1] = $signed(c.p0_y);
		p[2] = $signed(c.p1_x); p[3] = $signed(c.p1_y);
		p[4] = $signed(c.p2_x); p[5] = $signed(c.p2_y);
		p[6] = $signed(c.p3_x); p[7] = $signed(c.p3_y);
		den = c.density;
		for (int j = 0; j < 2; j++) begin
			longint a0, a1, a2, a3;
			a0 = p[j]; a1 = p[2 + j]; a2 = p[4 + j]; a3 = p[6 + j];
			if (j == 0) begin
				kx[0] = -a0 + 3 * a1 - 3 * a2 + a3;
				kx[1] = 3 * a0 - 6 * a1 + 3 * a2;
				kx[2] = -3 * a0 + 3 * a1;
				kx[3] = a0;
			end else begin
				ky[0] = -a0 + 3 * a1 - 3 * a2 + a3;
				ky[1] = 3 * a0 - 6 * a1 + 3 * a2;
				ky[2] = -3 * a0 + 3 * a1;
				ky[3] = a0;
			end
		end
		// Sample at uniform parameters
		for (longint unsigned i = 0; i < n; i++) begin
			ti = (i * 131072 + (n - 1)) / (2 * (n - 1));
			sx[i] = curve_at(kx[0], kx[1], kx[2], kx[3], longint'(ti));
			sy[i] = curve_at(ky[0], ky[1], ky[2], ky[3], longint'(ti));
		end
		// Accumulate chord lengths
		lens[0] = 0;
		total = 0;
		for (longint unsigned i = 1; i < n; i++) begin
			dx = sx[i] - sx[i - 1];
			dy = sy[i] - sy[i - 1];
			total += root_round(longint'(dx * dx) + longint'(dy * dy));
			lens[i] = total & 64'hFFFF_FFFF;
		end
		cnt = 1 + ((den * total + (64'd1 << 23)) >> 24);
		clip = 1'b0;
		if (cnt > MAX_POINTS) begin
			cnt = MAX_POINTS;
			clip = 1'b1;
		end
		if (cnt <= 1) begin
			r.out_x = c.p0_x;
			r.out_y = c.p0_y;
			r.last = 1'b1;
			r.clipped = clip;
			enqueue_point(r);
			return;
		end
		// Search the table for each target length and interpolate t
		for (longint unsigned i = 0; i < cnt; i++) begin
			tgt = (total * i * 2 + (cnt - 1)) / (2 * (cnt - 1));
			lo = 0;
			hi = int'(n) - 1;
			while (lo + 1 < hi) begin
				mid = (lo + hi) / 2;
				if (lens[mid] <= tgt) lo = mid;
				else hi = mid;
			end
			lb = lens[lo];
			span = lens[lo + 1] - lb;
			frac = 0;
			if (span != 0 && tgt > lb) begin
				frac = ((tgt - lb) * 131072 + span) / (2 * span);
				if (frac > 65536) frac = 65536;
			end
			tn = ((longint'(lo) * 65536 + frac) * 2 + (n - 1)) / (2 * (n - 1));
			if (tn > 65536) tn = 65536;
			vx = curve_at(kx[0], kx[1], kx[2], kx[3], longint'(tn));
			vy = curve_at(ky[0], ky[1], ky[2], ky[3], longint'(tn));
			r.out_x = 24'(vx);
			r.out_y = 24'(vy);
			r.last = (i + 1 == cnt);
			r.clipped = clip;
			enqueue_point(r);
		end
	endtask

	// Track the register, predict on each request, compare each point
	always @(posedge clk or negedge arst_n) begin
		bzr_out_t want;
		if (!arst_n) begin
			sample_setting = CHECK_POINTS_RST;
			expected_points.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) sample_setting = cfg_data;
			if (in_valid && in_ready) predict_curve(in_data);
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected point x=%0d y=%0d last=%b clipped=%b",
							$realtime, $signed(out_data.out_x), $signed(out_data.out_y),
							out_data.last, out_data.clipped);
				end else begin
					want = expected_points.pop_front();
					if (want.out_x !== out_data.out_x || want.out_y !== out_data.out_y ||
					    want.last !== out_data.last || want.clipped !== out_data.clipped) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: point x=%0d/%0d y=%0d/%0d last=%b/%b clip=%b/%b (exp/got)",
								$realtime, $signed(want.out_x), $signed(out_data.out_x),
								$signed(want.out_y), $signed(out_data.out_y),
								want.last, out_data.last, want.clipped, out_data.clipped);
					end
				end
			end
		end
		points_pending = expected_points.size();
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import bzr_pkg::*;

	localparam int STALL_LIMIT = 30000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic [5:0] cfg_data = '0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	bzr_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	bzr_out_t out_data;
	int       fail_count;
	int       points_pending;
	bit       idle_on = 1'b1;
	int       quiet_cycles = 0;
	int       hold_left = 0;

	always #5 clk = ~clk;

	bezier_arc_length_resampler_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	bzr_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .points_pending(points_pending)
	);

	// Stall the point stream in random bursts while idle_on is set
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(1, 12) - 1;
			rdy = 1'b0;
		end
		out_ready <= rdy;
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_samples(input logic [5:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold off new curves until every point has drained
	task automatic drain_points();
		in_valid <= 1'b0;
		while (points_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_curve(input bzr_in_t c);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic bzr_in_t make_curve(int signed x0, int signed y0, int signed x1,
		int signed y1, int signed x2, int signed y2, int signed x3, int signed y3,
		int unsigned dens);
		bzr_in_t c;
		c.p0_x = 24'(x0); c.p0_y = 24'(y0);
		c.p1_x = 24'(x1); c.p1_y = 24'(y1);
		c.p2_x = 24'(x2); c.p2_y = 24'(y2);
		c.p3_x = 24'(x3); c.p3_y = 24'(y3);
		c.density = 24'(dens);
		return c;
	endfunction

	// Mostly compact curves with moderate density, some full-range noise and single-point curves
	function automatic bzr_in_t random_curve();
		bzr_in_t c;
		int unsigned mode;
		int signed bx, by, sp;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			c = 216'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		end else if (mode == 1) begin
			bx = $urandom_range(0, 32'hFFFFFF) - 8388608;
			by = $urandom_range(0, 32'hFFFFFF) - 8388608;
			c = make_curve(bx, by, bx, by, bx, by, bx, by, $urandom);
		end else begin
			sp = 1 << $urandom_range(2, 16);
			bx = $urandom_range(0, 1 << 21) - (1 << 20);
			by = $urandom_range(0, 1 << 21) - (1 << 20);
			c = make_curve(bx, by,
				bx + $urandom_range(0, 2 * sp) - sp, by + $urandom_range(0, 2 * sp) - sp,
				bx + $urandom_range(0, 2 * sp) - sp, by + $urandom_range(0, 2 * sp) - sp,
				bx + $urandom_range(0, 2 * sp) - sp, by + $urandom_range(0, 2 * sp) - sp,
				$urandom_range(0, 1 << $urandom_range(4, 14)));
		end
		return c;
	endfunction

	initial begin
		logic [5:0] phase_setting[6] = '{6'd2, 6'd32, 6'd0, 6'd63, 6'd25, 6'd17};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed curves at the reset sample count
		send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_curve(make_curve(-8388608, -8388608, 8388607, -8388608,
			-8388608, 8388607, 8388607, 8388607, 24'hFFFFFF));
		send_curve(make_curve(8388607, 8388607, -8388608, 8388607,
			8388607, -8388608, -8388608, -8388608, 0));
		send_curve(make_curve(0, 0, 21845, 0, 43691, 0, 65536, 0, 16 * 256));
		send_curve(make_curve(0, 0, 21845, 0, 43691, 0, 65536, 0, 63 * 256));
		send_curve(make_curve(0, 0, 21845, 0, 43691, 0, 65536, 0, 64 * 256));
		send_curve(make_curve(100, -100, 100, -100, 100, -100, 102, -100, 24'hFFFFFF));
		send_curve(make_curve(0, 0, 0, 0, 0, 0, 5, 3, 24'h7FFFFF));
		send_curve(make_curve(0, 0, 65536, 65536, -65536, 65536, 0, 0, 2000));
		send_curve(make_curve(-300000, 5, 400000, 90000, 400000, -90000, -300000, 5, 300));
		drain_points();
		// Sample count below range, above range, then below it again
		write_samples(6'd0);
		send_curve(make_curve(0, 0, 30000, 60000, 60000, -60000, 90000, 0, 4000));
		send_curve(make_curve(10, 10, 10, 10, 10, 10, 12, 10, 24'hFFFFFF));
		drain_points();
		write_samples(6'd63);
		send_curve(make_curve(0, 0, 30000, 60000, 60000, -60000, 90000, 0, 4000));
		send_curve(make_curve(10, 10, 10, 10, 10, 10, 12, 10, 24'hFFFFFF));
		drain_points();
		write_samples(6'd1);
		send_curve(make_curve(-50000, 0, 0, 50000, 50000, 50000, 50000, 0, 9000));
		drain_points();

		// Random phases, each at its own sample count
		foreach (phase_setting[ph]) begin
			write_samples(ph == 5 ? 6'($urandom_range(2, 32)) : phase_setting[ph]);
			if (ph == 5) idle_on = 1'b0;
			repeat (23) send_curve(random_curve());
			drain_points();
		end

		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
